// ----- sv/v2a_pkg.sv -----
// Shared types and constants for the two-component vector ALU.
// Used by every module of the block; depends on nothing.
package v2a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ROOT_W        = 32;

    typedef enum logic [2:0] {
        FN_ADD,
        FN_SUB,
        FN_MUL,
        FN_SCALE,
        FN_DOT,
        FN_LEN_SQ,
        FN_LEN,
        FN_NORM
    } func_t;

    // Travels alongside the square root and divide pipelines.
    typedef struct packed {
        func_t               func;
        logic [DATA_W-1:0]   ex;
        logic [DATA_W-1:0]   ey;
        logic                esat;
        logic                sx;
        logic [DATA_W-1:0]   mx;
        logic                sy;
        logic [DATA_W-1:0]   my;
    } side_t;

endpackage

// ----- sv/v2a_front.sv -----
// Front end: products, sums, rounding and clamping for the simple operations.
// Three register stages. Depends on v2a_pkg.
module v2a_front #(
    parameter int FRAC_BITS = v2a_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  v2a_pkg::func_t      func,
    input  logic signed [31:0]  ax,
    input  logic signed [31:0]  ay,
    input  logic signed [31:0]  bx,
    input  logic signed [31:0]  by,
    input  logic signed [31:0]  scalar,
    output logic                out_valid,
    output logic [63:0]         sq_sum,
    output v2a_pkg::side_t      side
);
    import v2a_pkg::*;

    localparam logic signed [64:0] HALF65 = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [64:0] MAX65  = 65'sd2147483647;
    localparam logic signed [64:0] MIN65  = -65'sd2147483648;
    localparam logic signed [32:0] MAX33  = 33'sd2147483647;
    localparam logic signed [32:0] MIN33  = -33'sd2147483648;

    function automatic logic [32:0] rnd_sat(input logic signed [64:0] v);
        logic signed [64:0] t;
        t = (v + HALF65) >>> FRAC_BITS;
        if (t > MAX65)
            return {1'b1, 32'h7FFF_FFFF};
        else if (t < MIN65)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, t[31:0]};
    endfunction

    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        if (v > MAX33)
            return {1'b1, 32'h7FFF_FFFF};
        else if (v < MIN33)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    // stage 1
    logic signed [31:0] ma, mb, na, nb;
    logic signed [63:0] p0_c, p1_c;
    logic signed [32:0] sx_c, sy_c;

    logic               v1_reg;
    func_t              f1_reg;
    logic signed [63:0] p0_reg, p1_reg;
    logic signed [32:0] sx1_reg, sy1_reg;
    logic signed [31:0] ax1_reg, ay1_reg;

    always_comb
    begin
        ma = ax;
        na = ay;
        case (func)
            FN_SCALE:
            begin
                mb = scalar;
                nb = scalar;
            end
            FN_LEN_SQ, FN_LEN, FN_NORM:
            begin
                mb = ax;
                nb = ay;
            end
            default:
            begin
                mb = bx;
                nb = by;
            end
        endcase
    end

    assign p0_c = ma * mb;
    assign p1_c = na * nb;
    assign sx_c = (func == FN_SUB) ? 33'(ax) - 33'(bx) : 33'(ax) + 33'(bx);
    assign sy_c = (func == FN_SUB) ? 33'(ay) - 33'(by) : 33'(ay) + 33'(by);

    // stage 2
    logic [32:0]        rx2_c, ry2_c;
    logic               v2_reg;
    logic signed [64:0] s2_reg;
    side_t              side2_reg, side2_c;

    always_comb
    begin
        rx2_c = '0;
        ry2_c = '0;
        case (f1_reg)
            FN_ADD, FN_SUB:
            begin
                rx2_c = sat33(sx1_reg);
                ry2_c = sat33(sy1_reg);
            end
            FN_MUL, FN_SCALE:
            begin
                rx2_c = rnd_sat(65'(p0_reg));
                ry2_c = rnd_sat(65'(p1_reg));
            end
            default:
            begin
                rx2_c = '0;
                ry2_c = '0;
            end
        endcase
        side2_c.func = f1_reg;
        side2_c.ex   = rx2_c[31:0];
        side2_c.ey   = ry2_c[31:0];
        side2_c.esat = rx2_c[32] | ry2_c[32];
        side2_c.sx   = ax1_reg[31];
        side2_c.mx   = ax1_reg[31] ? 32'(-33'(ax1_reg)) : ax1_reg;
        side2_c.sy   = ay1_reg[31];
        side2_c.my   = ay1_reg[31] ? 32'(-33'(ay1_reg)) : ay1_reg;
    end

    // stage 3
    logic [32:0] rs3_c;
    side_t       side3_c;
    logic        v3_reg;
    logic [63:0] s3_reg;
    side_t       side3_reg;

    always_comb
    begin
        rs3_c   = rnd_sat(s2_reg);
        side3_c = side2_reg;
        if (side2_reg.func == FN_DOT || side2_reg.func == FN_LEN_SQ)
        begin
            side3_c.ex   = rs3_c[31:0];
            side3_c.ey   = '0;
            side3_c.esat = rs3_c[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg    <= func;
        p0_reg    <= p0_c;
        p1_reg    <= p1_c;
        sx1_reg   <= sx_c;
        sy1_reg   <= sy_c;
        ax1_reg   <= ax;
        ay1_reg   <= ay;
        s2_reg    <= 65'(p0_reg) + 65'(p1_reg);
        side2_reg <= side2_c;
        s3_reg    <= s2_reg[63:0];
        side3_reg <= side3_c;
    end

    assign out_valid = v3_reg;
    assign sq_sum    = s3_reg;
    assign side      = side3_reg;

endmodule

// ----- sv/v2a_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, then round to nearest.
// 33 register stages. Depends on v2a_pkg.
module v2a_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [63:0]               radicand,
    input  v2a_pkg::side_t            in_side,
    output logic                      out_valid,
    output logic [v2a_pkg::ROOT_W-1:0] root,
    output v2a_pkg::side_t            out_side
);
    import v2a_pkg::*;

    localparam int STEPS = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              val_reg  [0:STEPS-1];
    logic [ROOT_W-1:0] root_reg [0:STEPS-1];
    logic [REM_W-1:0]  rem_reg  [0:STEPS-1];
    logic [63:0]       v_reg    [0:STEPS-2];
    side_t             side_reg [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic              val_in;
        logic [63:0]       v_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_in;
        side_t             side_in;
        logic [REM_W+1:0]  pre, trial;

        if (k == 0)
        begin : g_first
            assign val_in  = in_valid;
            assign v_in    = radicand;
            assign root_in = '0;
            assign rem_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign val_in  = val_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign pre   = {rem_in, v_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[k] <= 1'b0;
            else
                val_reg[k] <= val_in;
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_in;
            if (pre >= trial)
            begin
                rem_reg[k]  <= REM_W'(pre - trial);
                root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= pre[REM_W-1:0];
                root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        if (k < STEPS - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                v_reg[k] <= v_in << 2;
            end
        end
    end

    // round to nearest: up when remainder exceeds the floor root
    logic              rnd_val_reg;
    logic [ROOT_W-1:0] rnd_root_reg;
    side_t             rnd_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_val_reg <= 1'b0;
        else
            rnd_val_reg <= val_reg[STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        rnd_side_reg <= side_reg[STEPS-1];
        if (rem_reg[STEPS-1] > REM_W'(root_reg[STEPS-1]))
            rnd_root_reg <= root_reg[STEPS-1] + 1'b1;
        else
            rnd_root_reg <= root_reg[STEPS-1];
    end

    assign out_valid = rnd_val_reg;
    assign root      = rnd_root_reg;
    assign out_side  = rnd_side_reg;

endmodule

// ----- sv/v2a_div.sv -----
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Computes (mag * 2^FRAC_BITS + den/2) / den. Depends on v2a_pkg.
module v2a_div #(
    parameter int FRAC_BITS = v2a_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [v2a_pkg::ROOT_W-1:0] den,
    input  v2a_pkg::side_t             in_side,
    output logic                       out_valid,
    output logic [FRAC_BITS:0]         qx,
    output logic [FRAC_BITS:0]         qy,
    output logic [v2a_pkg::ROOT_W-1:0] out_den,
    output v2a_pkg::side_t             out_side
);
    import v2a_pkg::*;

    localparam int QB   = FRAC_BITS + 1;
    localparam int NUMW = DATA_W + FRAC_BITS + 1;

    logic              val_reg  [0:QB];
    logic [NUMW-1:0]   remx_reg [0:QB];
    logic [NUMW-1:0]   remy_reg [0:QB];
    logic [QB-1:0]     qx_reg   [1:QB];
    logic [QB-1:0]     qy_reg   [1:QB];
    logic [ROOT_W-1:0] den_reg  [0:QB];
    side_t             side_reg [0:QB];

    // numerator set-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            val_reg[0] <= 1'b0;
        else
            val_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        remx_reg[0] <= (NUMW'(in_side.mx) << FRAC_BITS) + NUMW'(den >> 1);
        remy_reg[0] <= (NUMW'(in_side.my) << FRAC_BITS) + NUMW'(den >> 1);
        den_reg[0]  <= den;
        side_reg[0] <= in_side;
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        localparam int J = QB - k;
        logic [NUMW-1:0] dsh;
        logic [QB-1:0]   qx_in, qy_in;
        logic            tx, ty;

        if (k == 1)
        begin : g_first
            assign qx_in = '0;
            assign qy_in = '0;
        end
        else
        begin : g_next
            assign qx_in = qx_reg[k-1];
            assign qy_in = qy_reg[k-1];
        end

        assign dsh = NUMW'(den_reg[k-1]) << J;
        assign tx  = remx_reg[k-1] >= dsh;
        assign ty  = remy_reg[k-1] >= dsh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[k] <= 1'b0;
            else
                val_reg[k] <= val_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            remx_reg[k] <= tx ? remx_reg[k-1] - dsh : remx_reg[k-1];
            remy_reg[k] <= ty ? remy_reg[k-1] - dsh : remy_reg[k-1];
            qx_reg[k]   <= {qx_in[QB-2:0], tx};
            qy_reg[k]   <= {qy_in[QB-2:0], ty};
            den_reg[k]  <= den_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = val_reg[QB];
    assign qx        = qx_reg[QB];
    assign qy        = qy_reg[QB];
    assign out_den   = den_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

// ----- sv/vec2_arith_unit.sv -----
// Top level of the two-component vector ALU on signed fixed-point operands.
// Instantiates v2a_front, v2a_sqrt and v2a_div; depends on v2a_pkg.
//
// Usage:
//   Raise start with func, ax, ay, bx, by and scalar valid; the transfer
//   takes place at any rising edge with start high, and busy is always low,
//   so a new item may be presented in every cycle.
//   Every item passes through the same pipeline, whatever the operation:
//   3 front stages (products, sums, rounding), 33 square root stages,
//   FRAC_BITS+2 divide stages and one output register. The result shows on
//   rx, ry, saturated and div_zero with done high for exactly one cycle
//   once the item leaves the output register; operands are Q16.16 at the
//   default FRAC_BITS. Results leave in input order, one per cycle at most.
//   The receiver has no way to stall: it must take each result in the
//   cycle done is high.
//   Reset (rst_n low, asynchronous) clears every valid bit, so items in
//   flight are dropped and done stays low until new items come through.
module vec2_arith_unit #(
    parameter int FRAC_BITS = v2a_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic signed [31:0] ax,
    input  logic signed [31:0] ay,
    input  logic signed [31:0] bx,
    input  logic signed [31:0] by,
    input  logic signed [31:0] scalar,
    output logic               done,
    output logic signed [31:0] rx,
    output logic signed [31:0] ry,
    output logic               saturated,
    output logic               div_zero
);
    import v2a_pkg::*;

    logic              fe_valid;
    logic [63:0]       fe_sum;
    side_t             fe_side;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;
    logic              dv_valid;
    logic [FRAC_BITS:0] dv_qx, dv_qy;
    logic [ROOT_W-1:0] dv_len;
    side_t             dv_side;

    assign busy = 1'b0;

    v2a_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .func      (func_t'(func)),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by        (by),
        .scalar    (scalar),
        .out_valid (fe_valid),
        .sq_sum    (fe_sum),
        .side      (fe_side)
    );

    v2a_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .radicand  (fe_sum),
        .in_side   (fe_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    v2a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .den       (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .qx        (dv_qx),
        .qy        (dv_qy),
        .out_den   (dv_len),
        .out_side  (dv_side)
    );

    logic [31:0] rx_next, ry_next;
    logic        sat_next, dz_next;
    logic [31:0] qx_w, qy_w;

    logic        done_reg;
    logic [31:0] rx_reg, ry_reg;
    logic        sat_reg, dz_reg;

    assign qx_w = 32'(dv_qx);
    assign qy_w = 32'(dv_qy);

    always_comb
    begin
        rx_next  = dv_side.ex;
        ry_next  = dv_side.ey;
        sat_next = dv_side.esat;
        dz_next  = 1'b0;
        case (dv_side.func)
            FN_LEN:
            begin
                ry_next  = '0;
                sat_next = dv_len[ROOT_W-1];
                rx_next  = dv_len[ROOT_W-1] ? 32'h7FFF_FFFF : dv_len;
            end
            FN_NORM:
            begin
                sat_next = 1'b0;
                if (dv_len == '0)
                begin
                    dz_next = 1'b1;
                    rx_next = '0;
                    ry_next = '0;
                end
                else
                begin
                    rx_next = dv_side.sx ? -qx_w : qx_w;
                    ry_next = dv_side.sy ? -qy_w : qy_w;
                end
            end
            default:
            begin
                dz_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        sat_reg <= sat_next;
        dz_reg  <= dz_next;
    end

    assign done      = done_reg;
    assign rx        = rx_reg;
    assign ry        = ry_reg;
    assign saturated = sat_reg;
    assign div_zero  = dz_reg;

endmodule

// ----- test/vec2_arith_unit_tb.sv -----
// Self-checking testbench for vec2_arith_unit: random and directed vector operations.
// Predicts each result in-line and compares every done strobe; depends on v2a_pkg.
module vec2_arith_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import v2a_pkg::*;

    localparam int FB        = FRAC_BITS_DEF;
    localparam int LATENCY   = FB + 39;
    localparam int WDOG_MAX  = 2000;
    localparam longint MAXV  = 64'sd2147483647;
    localparam longint MINV  = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic        sat;
        logic        dz;
    } vres_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         func = '0;
    logic signed [31:0] ax = '0, ay = '0, bx = '0, by = '0, scalar = '0;
    logic               done;
    logic signed [31:0] rx, ry;
    logic               saturated, div_zero;

    vres_t  pending_res[$];
    int     n_fail = 0;
    int     n_sent = 0;
    int     n_recv = 0;
    int     idle_cnt = 0;
    bit     gaps_on = 1'b1;
    int     op_hits[8];

    vec2_arith_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .ax(ax), .ay(ay), .bx(bx), .by(by), .scalar(scalar), .done(done),
        .rx(rx), .ry(ry), .saturated(saturated), .div_zero(div_zero)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] clamp_q(input logic signed [65:0] v,
                                            inout bit sat);
        if (v > MAXV)
        begin
            sat = 1'b1;
            return MAXV[31:0];
        end
        if (v < MINV)
        begin
            sat = 1'b1;
            return MINV[31:0];
        end
        return v[31:0];
    endfunction

    // round half up from 2F fractional bits
    function automatic logic [31:0] round_q(input logic signed [65:0] v,
                                            inout bit sat);
        logic signed [65:0] t;
        t = (v + (66'sd1 <<< (FB - 1))) >>> FB;
        return clamp_q(t, sat);
    endfunction

    function automatic logic [63:0] root_near(input logic [63:0] v);
        logic [63:0] rem, res, bitv;
        rem = v;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        if (rem > res)
            res = res + 64'd1;
        return res;
    endfunction

    function automatic logic [31:0] unit_comp(input logic signed [31:0] c,
                                              input logic [63:0] len,
                                              inout bit sat);
        logic [95:0] mag, q;
        mag = (c < 0) ? 96'(-64'(c)) : 96'(c);
        q = ((mag << FB) + 96'(len >> 1)) / 96'(len);
        return clamp_q((c < 0) ? -$signed(66'(q)) : $signed(66'(q)), sat);
    endfunction

    function automatic vres_t vec_result(input func_t f,
                                         input logic signed [31:0] a0, a1, b0, b1, s);
        vres_t r;
        bit sat;
        logic signed [65:0] p0, p1;
        logic [63:0] sq, len;
        sat = 1'b0;
        r = '0;
        case (f)
            FN_ADD:
            begin
                r.rx = clamp_q(66'(a0) + 66'(b0), sat);
                r.ry = clamp_q(66'(a1) + 66'(b1), sat);
            end
            FN_SUB:
            begin
                r.rx = clamp_q(66'(a0) - 66'(b0), sat);
                r.ry = clamp_q(66'(a1) - 66'(b1), sat);
            end
            FN_MUL:
            begin
                r.rx = round_q(66'(a0) * 66'(b0), sat);
                r.ry = round_q(66'(a1) * 66'(b1), sat);
            end
            FN_SCALE:
            begin
                r.rx = round_q(66'(a0) * 66'(s), sat);
                r.ry = round_q(66'(a1) * 66'(s), sat);
            end
            FN_DOT:
                r.rx = round_q(66'(a0) * 66'(b0) + 66'(a1) * 66'(b1), sat);
            FN_LEN_SQ:
                r.rx = round_q(66'(a0) * 66'(a0) + 66'(a1) * 66'(a1), sat);
            FN_LEN:
            begin
                p0 = 66'(a0) * 66'(a0) + 66'(a1) * 66'(a1);
                len = root_near(p0[63:0]);
                if (len > 64'(MAXV))
                begin
                    sat = 1'b1;
                    r.rx = MAXV[31:0];
                end
                else
                    r.rx = len[31:0];
            end
            default:
            begin
                p1 = 66'(a0) * 66'(a0) + 66'(a1) * 66'(a1);
                sq = p1[63:0];
                if (sq == 0)
                    r.dz = 1'b1;
                else
                begin
                    len = root_near(sq);
                    r.rx = unit_comp(a0, len, sat);
                    r.ry = unit_comp(a1, len, sat);
                end
            end
        endcase
        r.sat = sat;
        return r;
    endfunction

    task automatic send_vec(input func_t f, input logic [31:0] a0, a1, b0, b1, s);
        int gap;
        if (gaps_on && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(15, 1);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        func <= f;
        ax <= a0;
        ay <= a1;
        bx <= b0;
        by <= b1;
        scalar <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_res.push_back(vec_result(f, a0, a1, b0, b1, s));
        op_hits[f]++;
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000 | ($urandom_range(3));
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
            3: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_0000,
                32'hFFFF_FFFF};
        for (int f = 0; f < 8; f++)
        begin
            send_vec(func_t'(f), ext[0], ext[0], ext[0], ext[0], ext[0]);
            send_vec(func_t'(f), ext[1], ext[1], ext[1], ext[0], ext[1]);
        end
        send_vec(FN_NORM, 0, 0, 0, 0, 0);
        send_vec(FN_NORM, ext[3], 0, 0, 0, 0);
        send_vec(FN_NORM, 0, ext[4], 0, 0, 0);
        send_vec(FN_NORM, 1, 1, 0, 0, 0);
        send_vec(FN_LEN, 0, 0, 0, 0, 0);
        send_vec(FN_MUL, 32'h0000_8000, ext[5], 32'h0000_0001, 32'h0000_8000, 0);
        send_vec(FN_DOT, ext[1], ext[1], ext[1], ext[1], 0);
        send_vec(FN_SCALE, ext[3], ext[4], 0, 0, ext[5]);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_vec(func_t'($urandom_range(7)), rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word());
    endtask

    task automatic test_hold_off();
        test_random(20);
        drain_results();
        test_random(20);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random(300);
    endtask

    always @(posedge clk)
    begin
        vres_t e;
        if (rst_n && done)
        begin
            n_recv++;
            if (pending_res.size() == 0)
            begin
                $error("result with nothing expected: rx=%h ry=%h", rx, ry);
                n_fail++;
            end
            else
            begin
                e = pending_res.pop_front();
                if (rx !== e.rx)
                begin
                    $error("rx expected %h actual %h", e.rx, rx);
                    n_fail++;
                end
                if (ry !== e.ry)
                begin
                    $error("ry expected %h actual %h", e.ry, ry);
                    n_fail++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %b actual %b", e.sat, saturated);
                    n_fail++;
                end
                if (div_zero !== e.dz)
                begin
                    $error("div_zero expected %b actual %b", e.dz, div_zero);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_MAX)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(1440);
        test_hold_off();
        test_back_to_back();
        drain_results();
        if (pending_res.size() != 0)
            n_fail++;
        $display("Covered %0d items over 8 operations (norm %0d, len %0d), %0d results.",
                 n_sent, op_hits[FN_NORM], op_hits[FN_LEN], n_recv);
        if (n_fail == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
